// ----- src/bvo_pkg.sv -----
// shared types and constants for the bounding volume overlap test
`default_nettype none

package bvo_pkg;

    // default coordinate width, Q16.16
    localparam int COORD_BITS = 32;

    // volume kind codes carried on the input beat
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SPHERE = 2'd1;
    localparam logic [1:0] KIND_BOX    = 2'd2;

    // which test the pair needs
    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_SPHERES,
        MODE_BOXES,
        MODE_MIXED
    } mode_t;

    // stage enables for a squarer
    typedef struct packed {
        logic part;
        logic comb;
    } sq_en_t;

endpackage

`default_nettype wire

// ----- src/bvo_pair_if.sv -----
// channel interface carrying one pair of bounding volumes
`default_nettype none

interface bvo_pair_if #(
    parameter int COORD_BITS = bvo_pkg::COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind_a;
    logic [1:0]                   kind_b;
    logic signed [COORD_BITS-1:0] offset_x;
    logic signed [COORD_BITS-1:0] offset_y;
    logic signed [COORD_BITS-1:0] offset_z;
    logic [COORD_BITS-2:0]        size_a_x;
    logic [COORD_BITS-2:0]        size_a_y;
    logic [COORD_BITS-2:0]        size_a_z;
    logic [COORD_BITS-2:0]        size_b_x;
    logic [COORD_BITS-2:0]        size_b_y;
    logic [COORD_BITS-2:0]        size_b_z;

    modport source (
        output valid, kind_a, kind_b, offset_x, offset_y, offset_z,
               size_a_x, size_a_y, size_a_z, size_b_x, size_b_y, size_b_z,
        input  ready
    );

    modport sink (
        input  valid, kind_a, kind_b, offset_x, offset_y, offset_z,
               size_a_x, size_a_y, size_a_z, size_b_x, size_b_y, size_b_z,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/bvo_result_if.sv -----
// channel interface carrying one overlap result
`default_nettype none

interface bvo_result_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/bvo_prep.sv -----
// magnitudes, clamped excesses, box test and selection of the values to square
`default_nettype none

module bvo_prep #(
    parameter int COORD_BITS = bvo_pkg::COORD_BITS
) (
    input  wire logic [1:0]            kind_a,
    input  wire logic [1:0]            kind_b,
    input  wire logic [COORD_BITS-1:0] offset [3],
    input  wire logic [COORD_BITS-2:0] size_a [3],
    input  wire logic [COORD_BITS-2:0] size_b [3],
    output logic      [COORD_BITS-1:0] operand [4],
    output bvo_pkg::mode_t             mode,
    output logic                       box_hit
);
    localparam int W = COORD_BITS;

    logic [W-1:0] mag [3];
    logic [W-1:0] ext_a [3];
    logic [W-1:0] ext_b [3];
    logic [W-1:0] ext_sum [3];
    logic [W-1:0] box_ext [3];
    logic [W-1:0] excess [3];
    logic [W-1:0] radius_sum;
    logic [W-1:0] radius;
    logic         a_is_sphere;

    always_comb
    begin
        box_hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            // magnitude of the most negative offset fits in w bits unsigned
            mag[i]     = offset[i][W-1] ? (~offset[i] + W'(1)) : offset[i];
            ext_a[i]   = {1'b0, size_a[i]};
            ext_b[i]   = {1'b0, size_b[i]};
            ext_sum[i] = ext_a[i] + ext_b[i];
            if (mag[i] > ext_sum[i])
            begin
                box_hit = 1'b0;
            end
        end
    end

    assign a_is_sphere = (kind_a == bvo_pkg::KIND_SPHERE);
    assign radius_sum  = ext_a[0] + ext_b[0];
    assign radius      = a_is_sphere ? ext_a[0] : ext_b[0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            box_ext[i] = a_is_sphere ? ext_b[i] : ext_a[i];
            excess[i]  = (mag[i] > box_ext[i]) ? (mag[i] - box_ext[i]) : '0;
        end
    end

    always_comb
    begin
        priority if (kind_a == bvo_pkg::KIND_SPHERE && kind_b == bvo_pkg::KIND_SPHERE)
        begin
            mode = bvo_pkg::MODE_SPHERES;
        end
        else if (kind_a == bvo_pkg::KIND_BOX && kind_b == bvo_pkg::KIND_BOX)
        begin
            mode = bvo_pkg::MODE_BOXES;
        end
        else if ((kind_a == bvo_pkg::KIND_SPHERE && kind_b == bvo_pkg::KIND_BOX) ||
                 (kind_a == bvo_pkg::KIND_BOX && kind_b == bvo_pkg::KIND_SPHERE))
        begin
            mode = bvo_pkg::MODE_MIXED;
        end
        else
        begin
            mode = bvo_pkg::MODE_NONE;
        end
    end

    always_comb
    begin
        if (mode == bvo_pkg::MODE_SPHERES)
        begin
            for (int i = 0; i < 3; i++)
            begin
                operand[i] = mag[i];
            end
            operand[3] = radius_sum;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                operand[i] = excess[i];
            end
            operand[3] = radius;
        end
    end
endmodule

`default_nettype wire

// ----- src/bvo_square.sv -----
// two-stage squarer built from half-width partial products
`default_nettype none

module bvo_square #(
    parameter int COORD_BITS = bvo_pkg::COORD_BITS
) (
    input  wire logic                    clk,
    input  wire bvo_pkg::sq_en_t         en,
    input  wire logic [COORD_BITS-1:0]   x,
    output logic      [2*COORD_BITS-1:0] sq
);
    localparam int W = COORD_BITS;
    localparam int L = (W + 1) / 2;
    localparam int H = W - L;

    logic [L-1:0]   lo;
    logic [H-1:0]   hi;
    logic [2*L-1:0] ll_reg;
    logic [L+H-1:0] lh_reg;
    logic [2*H-1:0] hh_reg;
    logic [2*W-1:0] sq_reg;
    logic [2*W-1:0] sq_next;

    assign lo = x[L-1:0];
    assign hi = x[W-1:L];

    // cross term appears twice in a square, hence the extra shift
    assign sq_next = {hh_reg, ll_reg} + ((2*W)'(lh_reg) << (L + 1));

    always_ff @(posedge clk)
    begin
        if (en.part)
        begin
            ll_reg <= lo * lo;
            lh_reg <= (L+H)'(lo) * (L+H)'(hi);
            hh_reg <= hi * hi;
        end
        if (en.comb)
        begin
            sq_reg <= sq_next;
        end
    end

    assign sq = sq_reg;
endmodule

`default_nettype wire

// ----- src/bounding_volume_overlap_test_top.sv -----
// top level of the sphere and axis-aligned box overlap test
// a result passes the capture, operand, partial product, square, distance and result registers in turn
// throughput: one pair per cycle while the result side does not stall, the six-stage pipeline has no loop
// stalls close bubbles first; input ready drops only when every stage is full
// reset (rst_n low, asynchronous) empties the pipeline; the data registers are not reset
`default_nettype none

module bounding_volume_overlap_test_top #(
    parameter int COORD_BITS = bvo_pkg::COORD_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bvo_pair_if.sink     pair,
    bvo_result_if.source result
);
    localparam int W = COORD_BITS;

    // per-stage valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // stage 1: captured pair
    logic [1:0]   kind_a_reg;
    logic [1:0]   kind_b_reg;
    logic [W-1:0] offset_reg [3];
    logic [W-2:0] size_a_reg [3];
    logic [W-2:0] size_b_reg [3];

    // stage 2: operands for the squarers plus box verdict
    logic [W-1:0]   operand_next [4];
    logic [W-1:0]   operand_reg [4];
    bvo_pkg::mode_t mode_next;
    bvo_pkg::mode_t mode2_reg, mode3_reg, mode4_reg, mode5_reg;
    logic           box_next;
    logic           box2_reg, box3_reg, box4_reg, box5_reg;

    // stages 3 and 4 live inside the squarers
    logic [2*W-1:0]  sq [4];
    bvo_pkg::sq_en_t sq_en;

    // stage 5: summed squares against the squared radius
    logic [2*W+1:0] dist_next;
    logic [2*W+1:0] dist_reg;
    logic [2*W-1:0] rad2_reg;

    // stage 6: result register
    logic hit_next;
    logic hit_reg;

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        en6 = !v6_reg || result.ready;
        en5 = !v5_reg || en6;
        en4 = !v4_reg || en5;
        en3 = !v3_reg || en4;
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;
    end

    assign pair.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pair.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // stage 1 capture of the beat
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            kind_a_reg    <= pair.kind_a;
            kind_b_reg    <= pair.kind_b;
            offset_reg[0] <= pair.offset_x;
            offset_reg[1] <= pair.offset_y;
            offset_reg[2] <= pair.offset_z;
            size_a_reg[0] <= pair.size_a_x;
            size_a_reg[1] <= pair.size_a_y;
            size_a_reg[2] <= pair.size_a_z;
            size_b_reg[0] <= pair.size_b_x;
            size_b_reg[1] <= pair.size_b_y;
            size_b_reg[2] <= pair.size_b_z;
        end
    end

    // magnitudes, clamping, box test, operand choice
    bvo_prep #(
        .COORD_BITS(COORD_BITS)
    ) u_prep (
        .kind_a (kind_a_reg),
        .kind_b (kind_b_reg),
        .offset (offset_reg),
        .size_a (size_a_reg),
        .size_b (size_b_reg),
        .operand(operand_next),
        .mode   (mode_next),
        .box_hit(box_next)
    );

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            operand_reg <= operand_next;
            mode2_reg   <= mode_next;
            box2_reg    <= box_next;
        end
        if (en3)
        begin
            mode3_reg <= mode2_reg;
            box3_reg  <= box2_reg;
        end
        if (en4)
        begin
            mode4_reg <= mode3_reg;
            box4_reg  <= box3_reg;
        end
    end

    assign sq_en.part = en3;
    assign sq_en.comb = en4;

    // three axis squares and the squared radius, in lockstep
    for (genvar k = 0; k < 4; k++)
    begin : g_square
        bvo_square #(
            .COORD_BITS(COORD_BITS)
        ) u_square (
            .clk(clk),
            .en (sq_en),
            .x  (operand_reg[k]),
            .sq (sq[k])
        );
    end

    // squared distance or squared residual, exact with two guard bits
    assign dist_next = (2*W+2)'(sq[0]) + (2*W+2)'(sq[1]) + (2*W+2)'(sq[2]);

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            dist_reg  <= dist_next;
            rad2_reg  <= sq[3];
            mode5_reg <= mode4_reg;
            box5_reg  <= box4_reg;
        end
    end

    // touching counts as a hit
    always_comb
    begin
        unique case (mode5_reg)
            bvo_pkg::MODE_SPHERES,
            bvo_pkg::MODE_MIXED:   hit_next = (dist_reg <= {2'b00, rad2_reg});
            bvo_pkg::MODE_BOXES:   hit_next = box5_reg;
            bvo_pkg::MODE_NONE:    hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            hit_reg <= hit_next;
        end
    end

    assign result.valid = v6_reg;
    assign result.hit   = hit_reg;
endmodule

`default_nettype wire

// ----- src/bvo_checker.sv -----
// port-level checks for the overlap test top, bound in below
`default_nettype none

module bvo_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic pair_valid,
    input wire logic pair_ready,
    input wire logic result_valid,
    input wire logic result_ready,
    input wire logic result_hit
);
    localparam int DEPTH = 6;

    logic [3:0] occ_reg;
    logic       take_in;
    logic       take_out;

    assign take_in  = pair_valid && pair_ready;
    assign take_out = result_valid && result_ready;

    // pairs accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_reg + 4'(take_in) - 4'(take_out);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped while stalled");

    a_hit_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_hit))
        else $error("result hit changed while stalled");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pair_ready |-> result_valid && !result_ready)
        else $error("input held off without a stalled result");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> occ_reg != 4'd0)
        else $error("result shown with no pair in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 4'(DEPTH))
        else $error("more pairs in flight than pipeline stages");
endmodule

bind bounding_volume_overlap_test_top bvo_checker u_bvo_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pair_valid  (pair.valid),
    .pair_ready  (pair.ready),
    .result_valid(result.valid),
    .result_ready(result.ready),
    .result_hit  (result.hit)
);

`default_nettype wire
